>>> hdl/assert_macros.svh
// Assertion macros used by the checker file qba_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define QBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a signal is unchanged in the cycle after a condition.
`define QBA_ASSERT_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

>>> hdl/qba_pkg.sv
`timescale 1ns / 1ps

package qba_pkg;

    localparam int QUAD_CAPACITY_DEF = 4096;
    localparam int MAX_SLOTS_DEF     = 32;

    localparam int TEX_SLOT_W    = 6;
    localparam int BATCH_COUNT_W = 13;

    localparam logic [TEX_SLOT_W-1:0] SLOT_LIMIT_RESET = 6'd16;

    typedef enum logic [1:0] {
        OP_PLAIN    = 2'd0,
        OP_TEXTURED = 2'd1,
        OP_FLUSH    = 2'd2,
        OP_RSVD     = 2'd3
    } opcode_t;

    typedef enum logic {
        KIND_VERTEX = 1'b0,
        KIND_FLUSH  = 1'b1
    } kind_t;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        size_x;
        logic [31:0]        size_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [31:0]        texture_id;
    } qba_in_t;

    typedef struct packed {
        kind_t                    kind;
        logic [1:0]               corner;
        logic signed [31:0]       vtx_x;
        logic signed [31:0]       vtx_y;
        logic signed [31:0]       vtx_z;
        logic [7:0]               out_red;
        logic [7:0]               out_green;
        logic [7:0]               out_blue;
        logic [7:0]               out_alpha;
        logic [TEX_SLOT_W-1:0]    tex_slot;
        logic [BATCH_COUNT_W-1:0] batch_count;
        logic                     last;
    } qba_out_t;

    // Add or subtract a half size and clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat_add(
        input logic signed [31:0] pos,
        input logic [30:0]        half,
        input logic               sub
    );
        logic signed [33:0] sum;
        logic signed [33:0] half_ext;
        half_ext = $signed({3'b000, half});
        sum      = sub ? (34'(pos) - half_ext) : (34'(pos) + half_ext);
        if ((sum[33] != sum[32]) || (sum[32] != sum[31]))
        begin
            return sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return $signed(sum[31:0]);
    endfunction

endpackage

>>> hdl/quad_batch_assembler.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload   | Beat
// quad    | in  | qba_in_t  | one draw request (plain, textured, end of frame)
// result  | out | qba_out_t | one vertex or one flush marker
// cfg     | in  | 6 bits    | texture slot limit per batch
//
// A quad yields four result beats, five when a flush marker leads it; an
// end-of-frame request yields one beat and a reserved opcode none. The output
// register takes one beat per cycle while result_ready allows, and the next
// request is taken in the cycle the last beat of the current one loads.
// Reset clears the quad count, the slot count and the beat counter, and sets
// the slot limit to 16. The texture table is not cleared: only entries below
// the slot count are compared. Low result_ready holds the output register
// and the request in flight; cfg_ready is always high.

module quad_batch_assembler
    import qba_pkg::*;
#(
    parameter int QUAD_CAPACITY = QUAD_CAPACITY_DEF,
    parameter int MAX_SLOTS     = MAX_SLOTS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  quad_valid,
    output logic                  quad_ready,
    input  qba_in_t               quad,
    output logic                  result_valid,
    input  logic                  result_ready,
    output qba_out_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TEX_SLOT_W-1:0] cfg_data
);

    localparam int QW = $clog2(QUAD_CAPACITY + 1);
    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    qba_in_t               item_reg;
    logic                  item_valid_reg;
    logic [2:0]            step_reg;
    logic [2:0]            step_next;
    qba_out_t              result_reg;
    qba_out_t              result_next;
    logic                  result_valid_reg;
    logic [QW-1:0]         quads_reg;
    logic [QW-1:0]         quads_next;
    logic [SW-1:0]         slots_reg;
    logic [SW-1:0]         slots_next;
    logic [31:0]           ids_reg [MAX_SLOTS];
    logic [TEX_SLOT_W-1:0] limit_reg;

    logic [TEX_SLOT_W-1:0] slot_limit;
    logic [MAX_SLOTS-1:0]  match;
    logic                  hit;
    logic [IW-1:0]         hit_idx;
    logic                  quad_op;
    logic                  tex_op;
    logic                  cap_flush;
    logic                  eff_hit;
    logic                  slot_flush;
    logic                  pre_flush;
    logic [QW-1:0]         base_quads;
    logic [SW-1:0]         base_slots;
    logic [TEX_SLOT_W-1:0] tex_val;
    logic [2:0]            n_res;
    logic                  marker_now;
    logic [1:0]            corner_idx;
    logic                  is_last;
    logic                  out_load;
    logic                  emit;
    logic                  finish;
    logic                  table_wr;

    // Clamp the configured slot limit to 1..MAX_SLOTS
    always_comb
    begin
        if (limit_reg == '0)
        begin
            slot_limit = TEX_SLOT_W'(1);
        end
        else if (limit_reg > TEX_SLOT_W'(MAX_SLOTS))
        begin
            slot_limit = TEX_SLOT_W'(MAX_SLOTS);
        end
        else
        begin
            slot_limit = limit_reg;
        end
    end

    // Compare the texture id against every live table entry
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            match[i] = (SW'(i) < slots_reg) && (ids_reg[i] == item_reg.texture_id);
            hit_idx  = hit_idx | (match[i] ? IW'(i) : '0);
        end
        hit = |match;
    end

    // Decide flushes and the slot of the request in flight
    assign quad_op    = (item_reg.opcode == OP_PLAIN) || (item_reg.opcode == OP_TEXTURED);
    assign tex_op     = (item_reg.opcode == OP_TEXTURED);
    assign cap_flush  = quad_op && (quads_reg >= QW'(QUAD_CAPACITY));
    assign eff_hit    = tex_op && hit && !cap_flush;
    assign slot_flush = tex_op && !eff_hit && !cap_flush
                        && (TEX_SLOT_W'(slots_reg) >= slot_limit);
    assign pre_flush  = cap_flush || slot_flush;
    assign base_quads = pre_flush ? '0 : quads_reg;
    assign base_slots = pre_flush ? '0 : slots_reg;

    always_comb
    begin
        if (!tex_op)
        begin
            tex_val = '0;
        end
        else if (eff_hit)
        begin
            tex_val = TEX_SLOT_W'(hit_idx) + TEX_SLOT_W'(1);
        end
        else
        begin
            tex_val = TEX_SLOT_W'(base_slots) + TEX_SLOT_W'(1);
        end
    end

    // Count the beats this request produces
    always_comb
    begin
        unique case (item_reg.opcode) inside
            OP_PLAIN, OP_TEXTURED: n_res = pre_flush ? 3'd5 : 3'd4;
            OP_FLUSH:              n_res = 3'd1;
            default:               n_res = 3'd0;
        endcase
    end

    assign marker_now = (item_reg.opcode == OP_FLUSH) || (pre_flush && (step_reg == 3'd0));
    assign corner_idx = pre_flush ? 2'(step_reg - 3'd1) : step_reg[1:0];
    assign is_last    = (step_reg == (n_res - 3'd1));

    // Build the next result beat
    always_comb
    begin
        result_next = '0;
        if (marker_now)
        begin
            result_next.kind        = KIND_FLUSH;
            result_next.tex_slot    = TEX_SLOT_W'(slots_reg);
            result_next.batch_count = BATCH_COUNT_W'(quads_reg);
        end
        else
        begin
            result_next.kind        = KIND_VERTEX;
            result_next.corner      = corner_idx;
            result_next.vtx_x       = sat_add(item_reg.pos_x, item_reg.size_x[31:1],
                                              (corner_idx == 2'd0) || (corner_idx == 2'd3));
            result_next.vtx_y       = sat_add(item_reg.pos_y, item_reg.size_y[31:1],
                                              (corner_idx == 2'd0) || (corner_idx == 2'd1));
            result_next.vtx_z       = item_reg.pos_z;
            result_next.out_red     = item_reg.red;
            result_next.out_green   = item_reg.green;
            result_next.out_blue    = item_reg.blue;
            result_next.out_alpha   = item_reg.alpha;
            result_next.tex_slot    = tex_val;
            result_next.batch_count = BATCH_COUNT_W'(base_quads);
        end
        result_next.last = is_last;
    end

    // Handshake between the request register and the output register
    assign out_load   = !result_valid_reg || result_ready;
    assign emit       = item_valid_reg && (n_res != 3'd0) && out_load;
    assign finish     = item_valid_reg && ((n_res == 3'd0) || (out_load && is_last));
    assign quad_ready = !item_valid_reg || finish;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Advance the beat counter per beat and update the batch state at the end of a request
    always_comb
    begin
        step_next  = step_reg;
        quads_next = quads_reg;
        slots_next = slots_reg;
        table_wr   = 1'b0;
        if (finish)
        begin
            step_next = '0;
            case (item_reg.opcode) inside
                OP_FLUSH:
                begin
                    quads_next = '0;
                    slots_next = '0;
                end
                OP_PLAIN, OP_TEXTURED:
                begin
                    quads_next = base_quads + QW'(1);
                    if (tex_op && !eff_hit)
                    begin
                        slots_next = base_slots + SW'(1);
                        table_wr   = (base_slots < SW'(MAX_SLOTS));
                    end
                    else
                    begin
                        slots_next = base_slots;
                    end
                end
                default:
                begin
                    quads_next = quads_reg;
                end
            endcase
        end
        else if (emit)
        begin
            step_next = step_reg + 3'd1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            step_reg         <= '0;
            quads_reg        <= '0;
            slots_reg        <= '0;
            limit_reg        <= SLOT_LIMIT_RESET;
        end
        else
        begin
            if (quad_ready)
            begin
                item_valid_reg <= quad_valid;
            end
            if (out_load)
            begin
                result_valid_reg <= emit;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            step_reg  <= step_next;
            quads_reg <= quads_next;
            slots_reg <= slots_next;
        end
    end

    // Payload registers and texture table
    always_ff @(posedge clk)
    begin
        if (quad_valid && quad_ready)
        begin
            item_reg <= quad;
        end
        if (emit)
        begin
            result_reg <= result_next;
        end
        if (table_wr)
        begin
            ids_reg[base_slots[IW-1:0]] <= item_reg.texture_id;
        end
    end

endmodule

>>> hdl/qba_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qba_checker
    import qba_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     result_valid,
    input logic     result_ready,
    input qba_out_t result
);

    // Hold a stalled result beat
    `QBA_ASSERT_HOLD(a_result_hold, result_valid && !result_ready, result, "stalled result beat changed")

    // A flush marker that leads a quad is followed at once by its first corner
    `QBA_ASSERT(a_marker_then_corner0, result_valid && result_ready && (result.kind == KIND_FLUSH) && !result.last |=> result_valid && (result.kind == KIND_VERTEX) && (result.corner == 2'd0), "flush marker not followed by corner 0")

    // Corners of one quad leave in order without gaps
    `QBA_ASSERT(a_corner_order, result_valid && result_ready && (result.kind == KIND_VERTEX) && (result.corner != 2'd3) |=> result_valid && (result.kind == KIND_VERTEX) && (result.corner == ($past(result.corner) + 2'd1)), "vertex corners out of order")

    // The last corner closes the quad and only it
    `QBA_ASSERT(a_last_on_corner3, result_valid && (result.kind == KIND_VERTEX) |-> (result.last == (result.corner == 2'd3)), "last flag not on corner 3")

endmodule

bind quad_batch_assembler qba_checker u_qba_checker (.*);
